[sv/aqr_pkg.sv]
// ----------------------------------------------------------------------------
// AES quadrant round unit - shared definitions
// Opcodes, the AES S-box table and the GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aqr_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OP_W   = 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [OP_W-1:0] {
		OP_SUB_UPPER = 2'd0,
		OP_SUB_LOWER = 2'd1,
		OP_MIX       = 2'd2,
		OP_RSVD      = 2'd3
	} op_t;

	// AES field polynomial x^8+x^4+x^3+x+1, low byte
	localparam byte_t GF_POLY = 8'h1b;

	localparam byte_t SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic byte_t sub_byte(input byte_t x);
		return SBOX[x];
	endfunction

	// multiply by x in GF(2^8)
	function automatic byte_t xtime(input byte_t x);
		return {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY : '0);
	endfunction

endpackage

[sv/aqr_req_if.sv]
// ----------------------------------------------------------------------------
// AES quadrant round unit - request channel
// Valid/ready channel carrying the opcode and both quadrant words.
// ----------------------------------------------------------------------------
interface aqr_req_if;
	logic                          valid;
	logic                          ready;
	logic [aqr_pkg::OP_W-1:0]      op;
	logic [aqr_pkg::WORD_W-1:0]    operand_a;
	logic [aqr_pkg::WORD_W-1:0]    operand_b;

	modport source (output valid, output op, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

[sv/aqr_rsp_if.sv]
// ----------------------------------------------------------------------------
// AES quadrant round unit - response channel
// Valid/ready channel carrying the new quadrant word.
// ----------------------------------------------------------------------------
interface aqr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [aqr_pkg::WORD_W-1:0]    result;

	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

[sv/aes_quadrant_round_instructions.sv]
// Path: an accepted request is held in the input register, then the result
//   register, whose contents drive the response.
// Throughput: one word per cycle; the S-box lanes and MixColumns XOR net sit
//   between the two registers, and the request side stalls only while both
//   stages are full and the response is not taken.
// Reset: arst_n clears both stage valid bits; no word is in flight after it.
// ----------------------------------------------------------------------------
// AES quadrant round unit - top level
// Two-stage valid/ready pipe around SubBytes/ShiftRows and MixColumns logic.
// ----------------------------------------------------------------------------
module aes_quadrant_round_instructions (
	input  logic       clk,
	input  logic       arst_n,
	aqr_req_if.sink    req,
	aqr_rsp_if.source  rsp
);
	// stage 1: registered request word
	logic            valid_s1;
	aqr_pkg::op_t    op_s1;
	aqr_pkg::word_t  a_s1;
	aqr_pkg::word_t  b_s1;

	// stage 2: registered result word
	logic            valid_s2;
	aqr_pkg::word_t  result_s2;

	logic            take_req;
	logic            s2_free;
	logic            load_s2;

	aqr_pkg::word_t  sub_word;
	aqr_pkg::word_t  mix_word;
	aqr_pkg::word_t  next_result;

	// stage 2 can take a word when empty or when its word leaves this cycle
	assign s2_free   = !valid_s2 || rsp.ready;
	assign load_s2   = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;
	assign take_req  = req.valid && req.ready;

	aqr_sub u_sub (
		.lower  (op_s1 == aqr_pkg::OP_SUB_LOWER),
		.a      (a_s1),
		.b      (b_s1),
		.result (sub_word)
	);

	aqr_mix u_mix (
		.a      (a_s1),
		.b      (b_s1),
		.result (mix_word)
	);

	// opcode select; reserved code gives zero
	always_comb begin
		case (op_s1)
			aqr_pkg::OP_SUB_UPPER,
			aqr_pkg::OP_SUB_LOWER: next_result = sub_word;
			aqr_pkg::OP_MIX:       next_result = mix_word;
			default:               next_result = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_req) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (take_req) begin
			op_s1 <= aqr_pkg::op_t'(req.op);
			a_s1  <= req.operand_a;
			b_s1  <= req.operand_b;
		end
		if (load_s2) begin
			result_s2 <= next_result;
		end
	end

	assign rsp.valid  = valid_s2;
	assign rsp.result = result_s2;

`ifndef NO_ASSERTIONS
	// a full pipe with a stalled response must hold off new requests
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !rsp.ready) |-> !req.ready)
		else $error("request accepted into a full stalled pipe");

	// reserved opcode moving into stage 2 leaves a zero word there
	a_rsvd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && op_s1 == aqr_pkg::OP_RSVD) |=> (valid_s2 && result_s2 == '0))
		else $error("reserved opcode produced nonzero result");

	// a stage-1 word that moves on and is not replaced empties stage 1
	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && !take_req) |=> !valid_s1)
		else $error("stage 1 word duplicated");
`endif

endmodule

[sv/aqr_sub.sv]
// ----------------------------------------------------------------------------
// AES quadrant round unit - SubBytes/ShiftRows lanes
// Four S-box lookups on the bytes that ShiftRows brings into the quadrant.
// ----------------------------------------------------------------------------
module aqr_sub (
	input  logic           lower,
	input  aqr_pkg::word_t a,
	input  aqr_pkg::word_t b,
	output aqr_pkg::word_t result
);
	aqr_pkg::word_t own;
	aqr_pkg::word_t partner;

	// lower half swaps the roles of the two words
	assign own     = lower ? b : a;
	assign partner = lower ? a : b;

	assign result = {aqr_pkg::sub_byte(own[31:24]),
	                 aqr_pkg::sub_byte(own[23:16]),
	                 aqr_pkg::sub_byte(own[7:0]),
	                 aqr_pkg::sub_byte(partner[15:8])};
endmodule

[sv/aqr_mix.sv]
// ----------------------------------------------------------------------------
// AES quadrant round unit - MixColumns
// Builds two columns from interleaved bytes, keeps their top two output rows.
// ----------------------------------------------------------------------------
module aqr_mix (
	input  aqr_pkg::word_t a,
	input  aqr_pkg::word_t b,
	output aqr_pkg::word_t result
);
	aqr_pkg::word_t p;
	aqr_pkg::word_t q;
	aqr_pkg::byte_t p0, p1, q0, q1;

	assign p = {a[31:24], a[15:8], b[31:24], b[15:8]};
	assign q = {a[23:16], a[7:0],  b[23:16], b[7:0]};

	// rows 0 and 1 of the MixColumns matrix: {2 3 1 1} and {1 2 3 1}
	assign p0 = aqr_pkg::xtime(p[31:24]) ^ aqr_pkg::xtime(p[23:16]) ^ p[23:16]
	          ^ p[15:8] ^ p[7:0];
	assign p1 = p[31:24] ^ aqr_pkg::xtime(p[23:16]) ^ aqr_pkg::xtime(p[15:8])
	          ^ p[15:8] ^ p[7:0];
	assign q0 = aqr_pkg::xtime(q[31:24]) ^ aqr_pkg::xtime(q[23:16]) ^ q[23:16]
	          ^ q[15:8] ^ q[7:0];
	assign q1 = q[31:24] ^ aqr_pkg::xtime(q[23:16]) ^ aqr_pkg::xtime(q[15:8])
	          ^ q[15:8] ^ q[7:0];

	assign result = {p0, q0, p1, q1};
endmodule
